// ===== design/mdqla_pkg.sv =====
// shared types, constants and saturating helpers for the multi-drive q-learning agent
package mdqla_pkg;

   localparam int NUM_DRIVES  = 2;
   localparam int NUM_STATES  = 64;
   localparam int NUM_ACTIONS = 5;

   localparam int Q_ENTRIES = NUM_DRIVES * NUM_STATES * NUM_ACTIONS;
   localparam int ADDR_W    = $clog2(Q_ENTRIES);
   localparam int DRV_W     = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
   localparam int STATE_W   = 6;
   localparam int ACT_W     = 3;
   localparam int NEED_W    = 2;
   localparam int COEF_W    = 17;
   localparam int REQ_W     = 160;
   localparam int RSP_W     = 8;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [31:0] q_type;

   localparam q_type Q_MAX      = 32'sh7fff_ffff;
   localparam q_type Q_MIN      = 32'sh8000_0000;
   localparam q_type NEAR_LIMIT = 32'sd65470464;   // 999.0 in q16.16

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_DECAY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLOIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT    = 3'd4;

   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEL_DRIVE,
      ST_SEL_BASE,
      ST_SEL_RD,
      ST_SEL_MUL,
      ST_SEL_CMP,
      ST_UPD_DECAY,
      ST_UPD_LEVEL,
      ST_UPD_MAX,
      ST_UPD_GMUL,
      ST_UPD_RPE,
      ST_UPD_AMUL,
      ST_UPD_WR,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef;
      q_type             operand;
   } mul_req_type;

   function automatic q_type sat_add(q_type a, q_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
      return s[31:0];
   endfunction

   function automatic q_type sat_sub(q_type a, q_type b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
      return s[31:0];
   endfunction

   function automatic q_type sat_abs(q_type a);
      if (a == Q_MIN) return Q_MAX;
      return a[31] ? -a : a;
   endfunction

   function automatic logic [ADDR_W-1:0] q_addr(logic [DRV_W-1:0] d,
                                                logic [STATE_W-1:0] s,
                                                logic [ACT_W-1:0] a);
      logic [ADDR_W-1:0] row;
      row = ADDR_W'(d) * ADDR_W'(NUM_STATES) + ADDR_W'(s);
      return ADDR_W'(row * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a));
   endfunction

endpackage

// ===== design/mdqla_mul.sv =====
// shared coefficient multiplier: q1.16 times q16.16, floor, saturate, registered
module mdqla_mul (
   input  logic                 clock,
   input  mdqla_pkg::mul_req_type req,
   output mdqla_pkg::q_type       product_ff
);
   import mdqla_pkg::*;

   logic signed [49:0] prod;
   logic signed [33:0] shr;
   q_type              product_in;

   always_comb begin
      prod = $signed({1'b0, req.coef}) * req.operand;
      shr  = prod[49:16];   // arithmetic shift gives floor rounding
      if (shr > 34'sd2147483647) begin
         product_in = Q_MAX;
      end else if (shr < -34'sd2147483648) begin
         product_in = Q_MIN;
      end else begin
         product_in = shr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== design/mdqla_qmem.sv =====
// q table storage, one write and one registered read per cycle
module mdqla_qmem (
   input  logic                          clock,
   input  logic                          we,
   input  logic [mdqla_pkg::ADDR_W-1:0]  waddr,
   input  mdqla_pkg::q_type              wdata,
   input  logic [mdqla_pkg::ADDR_W-1:0]  raddr,
   output mdqla_pkg::q_type              rdata_ff
);
   import mdqla_pkg::*;

   q_type mem [Q_ENTRIES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

// ===== design/multi_drive_q_learning_agent.sv =====
// top level: sequencer and datapath of the multi-drive q-learning agent
//
// req channel carries one word per item: tuser is the operation (0 select,
// 1 update), tdata the states, rewards and random inputs. rsp returns one word
// per item: the chosen action, the neediest drive and the explored flag.
// csr writes go straight into the coefficient registers; write them only
// while no item is in flight.
// every item is walked through one shared multiplier and one q table read port.
// select checks each drive in turn; for each drive that becomes the neediest
// it forms a base, then reads, multiplies and compares every action. update
// runs decay, level, a max scan, gamma multiply, rpe, alpha multiply and write
// per drive. the result is registered in the final step and req_tready is low
// from accept until the result is loaded into the output register.
// after reset all 640 q table entries are cleared one entry a cycle; no item
// is taken meanwhile. a stalled rsp holds the block in its final step until
// the waiting word is taken; a new item is accepted while the last word waits.
module multi_drive_q_learning_agent (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cur_state, next_state, reward_0..reward_3, random_draw, random_action
   input  logic [mdqla_pkg::REQ_W-1:0]       req_tdata,
   // operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chosen_action, neediest_drive, explored
   output logic [mdqla_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                              csr_we,
   input  logic [mdqla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_wdata
);
   import mdqla_pkg::*;

   seq_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [15:0] alpha_ff, gamma_ff, zeta_ff;
   logic [16:0] eps_ff;
   q_type       hopt_ff;

   q_type lvl_ff [NUM_DRIVES];
   q_type lvl_in [NUM_DRIVES];
   q_type rwd_ff [NUM_DRIVES];
   q_type rwd_in [NUM_DRIVES];

   logic [STATE_W-1:0] held_state_ff, held_state_in;
   logic [ACT_W-1:0]   held_action_ff, held_action_in;
   logic               op_ff, op_in;
   logic [STATE_W-1:0] nstate_ff, nstate_in;
   logic [15:0]        draw_ff, draw_in;
   logic [ACT_W-1:0]   ract_ff, ract_in;

   logic [DRV_W-1:0]  drv_ff, drv_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ACT_W-1:0]  greedy_ff, greedy_in;
   q_type best_dist_ff, best_dist_in;
   q_type best_a_ff, best_a_in;
   q_type base_ff, base_in;
   q_type qmax_ff, qmax_in;
   q_type rpe_ff, rpe_in;
   q_type qk_ff, qk_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]  rsp_action_ff, rsp_action_in;
   logic [NEED_W-1:0] rsp_need_ff, rsp_need_in;
   logic              rsp_expl_ff, rsp_expl_in;

   logic req_fire, drv_last, act_last, slot_free, dist_wins;
   q_type drv_dist, err;
   logic [ACT_W-1:0] ract_red;
   logic explore;

   mul_req_type       mul_req;
   q_type             mul_q;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   q_type             mem_wdata, mem_q;

   mdqla_mul u_mul (
      .clock      (clock),
      .req        (mul_req),
      .product_ff (mul_q)
   );

   mdqla_qmem u_qmem (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .raddr    (mem_raddr),
      .rdata_ff (mem_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_expl_ff, rsp_need_ff, rsp_action_ff};

   assign drv_last  = (drv_ff == DRV_W'(NUM_DRIVES - 1));
   assign act_last  = (act_ff == ACT_W'(NUM_ACTIONS - 1));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign drv_dist  = sat_abs(sat_sub(hopt_ff, lvl_ff[drv_ff]));
   assign dist_wins = (drv_dist > best_dist_ff);
   assign err       = sat_abs(sat_sub(base_ff, mul_q));
   // random action is below 8, one subtract brings it under the action count
   assign ract_red  = (ract_ff >= ACT_W'(NUM_ACTIONS)) ? ract_ff - ACT_W'(NUM_ACTIONS)
                                                       : ract_ff;
   assign explore   = !({1'b0, draw_ff} < eps_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_cnt_ff == ADDR_W'(Q_ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) state_in = (req_tuser == OP_SELECT) ? ST_SEL_DRIVE : ST_UPD_DECAY;
         end
         ST_SEL_DRIVE: begin
            if (dist_wins) state_in = ST_SEL_BASE;
            else if (drv_last) state_in = ST_DONE;
         end
         ST_SEL_BASE:  state_in = ST_SEL_RD;
         ST_SEL_RD:    state_in = ST_SEL_MUL;
         ST_SEL_MUL:   state_in = ST_SEL_CMP;
         ST_SEL_CMP: begin
            if (!act_last) state_in = ST_SEL_RD;
            else if (drv_last) state_in = ST_DONE;
            else state_in = ST_SEL_DRIVE;
         end
         ST_UPD_DECAY: state_in = ST_UPD_LEVEL;
         ST_UPD_LEVEL: state_in = ST_UPD_MAX;
         ST_UPD_MAX:   if (act_last) state_in = ST_UPD_GMUL;
         ST_UPD_GMUL:  state_in = ST_UPD_RPE;
         ST_UPD_RPE:   state_in = ST_UPD_AMUL;
         ST_UPD_AMUL:  state_in = ST_UPD_WR;
         ST_UPD_WR:    state_in = drv_last ? ST_DONE : ST_UPD_DECAY;
         ST_DONE:      if (slot_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // multiplier and table port control
   always_comb begin
      mul_req.coef    = {1'b0, zeta_ff};
      mul_req.operand = lvl_ff[drv_ff];
      mem_we          = 1'b0;
      mem_waddr       = clr_cnt_ff;
      mem_wdata       = '0;
      mem_raddr       = q_addr(drv_ff, held_state_ff, act_ff);
      unique case (state_ff)
         ST_CLEAR:     mem_we = 1'b1;
         ST_SEL_MUL: begin
            mul_req.coef    = COEF_W'(17'd65536 - {1'b0, gamma_ff});
            mul_req.operand = mem_q;
         end
         ST_UPD_DECAY: mem_raddr = q_addr(drv_ff, nstate_ff, '0);
         ST_UPD_LEVEL: mem_raddr = q_addr(drv_ff, nstate_ff, ACT_W'(1));
         ST_UPD_MAX:   mem_raddr = q_addr(drv_ff, nstate_ff, act_ff + ACT_W'(1));
         ST_UPD_GMUL: begin
            mul_req.coef    = {1'b0, gamma_ff};
            mul_req.operand = qmax_ff;
            mem_raddr       = q_addr(drv_ff, held_state_ff, held_action_ff);
         end
         ST_UPD_AMUL: begin
            mul_req.coef    = {1'b0, alpha_ff};
            mul_req.operand = rpe_ff;
         end
         ST_UPD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = q_addr(drv_ff, held_state_ff, held_action_ff);
            mem_wdata = sat_add(qk_ff, mul_q);
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      lvl_in         = lvl_ff;
      rwd_in         = rwd_ff;
      held_state_in  = held_state_ff;
      held_action_in = held_action_ff;
      op_in          = op_ff;
      nstate_in      = nstate_ff;
      draw_in        = draw_ff;
      ract_in        = ract_ff;
      drv_in         = drv_ff;
      act_in         = act_ff;
      need_in        = need_ff;
      greedy_in      = greedy_ff;
      best_dist_in   = best_dist_ff;
      best_a_in      = best_a_ff;
      base_in        = base_ff;
      qmax_in        = qmax_ff;
      rpe_in         = rpe_ff;
      qk_in          = qk_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_action_in  = rsp_action_ff;
      rsp_need_in    = rsp_need_ff;
      rsp_expl_in    = rsp_expl_ff;
      unique case (state_ff)
         ST_CLEAR: clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (req_fire) begin
               op_in        = req_tuser;
               nstate_in    = req_tdata[11:6];
               draw_in      = req_tdata[155:140];
               ract_in      = req_tdata[158:156];
               drv_in       = '0;
               need_in      = '0;
               greedy_in    = '0;
               best_dist_in = '0;
               for (int d = 0; d < NUM_DRIVES; d++) begin
                  rwd_in[d] = req_tdata[12 + 32 * d +: 32];
               end
               if (req_tuser == OP_SELECT) held_state_in = req_tdata[5:0];
            end
         end
         ST_SEL_DRIVE: begin
            if (dist_wins) begin
               best_dist_in = drv_dist;
               need_in      = NEED_W'(drv_ff);
            end else if (!drv_last) begin
               drv_in = drv_ff + DRV_W'(1);
            end
         end
         ST_SEL_BASE: begin
            base_in   = sat_sub(hopt_ff, mul_q);
            best_a_in = NEAR_LIMIT;
            act_in    = '0;
         end
         ST_SEL_CMP: begin
            if (err < best_a_ff) begin
               best_a_in = err;
               greedy_in = act_ff;
            end
            if (!act_last) act_in = act_ff + ACT_W'(1);
            else if (!drv_last) drv_in = drv_ff + DRV_W'(1);
         end
         ST_UPD_LEVEL: begin
            lvl_in[drv_ff] = sat_add(mul_q, rwd_ff[drv_ff]);
            qmax_in        = mem_q;
            act_in         = ACT_W'(1);
         end
         ST_UPD_MAX: begin
            if (mem_q > qmax_ff) qmax_in = mem_q;
            if (!act_last) act_in = act_ff + ACT_W'(1);
         end
         ST_UPD_RPE: begin
            rpe_in = sat_sub(sat_add(rwd_ff[drv_ff], mul_q), mem_q);
            qk_in  = mem_q;
         end
         ST_UPD_WR: if (!drv_last) drv_in = drv_ff + DRV_W'(1);
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_SELECT) begin
                  held_action_in = explore ? ract_red : greedy_ff;
                  rsp_action_in  = explore ? ract_red : greedy_ff;
                  rsp_need_in    = need_ff;
                  rsp_expl_in    = explore;
               end else begin
                  rsp_action_in = held_action_ff;
                  rsp_need_in   = '0;
                  rsp_expl_in   = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         held_state_ff  <= '0;
         held_action_ff <= '0;
         for (int d = 0; d < NUM_DRIVES; d++) begin
            lvl_ff[d] <= '0;
         end
         alpha_ff <= 16'd6554;
         gamma_ff <= 16'd58982;
         zeta_ff  <= 16'd65209;
         eps_ff   <= 17'd52429;
         hopt_ff  <= 32'sd327680;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_state_ff  <= held_state_in;
         held_action_ff <= held_action_in;
         lvl_ff         <= lvl_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEARN_RATE:  alpha_ff <= csr_wdata[15:0];
               CSR_DISCOUNT:    gamma_ff <= csr_wdata[15:0];
               CSR_DRIVE_DECAY: zeta_ff  <= csr_wdata[15:0];
               CSR_EXPLOIT:     eps_ff   <= csr_wdata[16:0];
               CSR_SETPOINT:    hopt_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rwd_ff        <= rwd_in;
      op_ff         <= op_in;
      nstate_ff     <= nstate_in;
      draw_ff       <= draw_in;
      ract_ff       <= ract_in;
      drv_ff        <= drv_in;
      act_ff        <= act_in;
      need_ff       <= need_in;
      greedy_ff     <= greedy_in;
      best_dist_ff  <= best_dist_in;
      best_a_ff     <= best_a_in;
      base_ff       <= base_in;
      qmax_ff       <= qmax_in;
      rpe_ff        <= rpe_in;
      qk_ff         <= qk_in;
      rsp_action_ff <= rsp_action_in;
      rsp_need_ff   <= rsp_need_in;
      rsp_expl_ff   <= rsp_expl_in;
   end

endmodule

// ===== dv/multi_drive_q_learning_agent_test.sv =====
// self-checking testbench for the multi-drive q-learning agent
module multi_drive_q_learning_agent_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mdqla_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      logic       explored;
      logic [1:0] neediest_drive;
      logic [2:0] chosen_action;
   } agent_result_type;

   typedef struct {
      logic        operation;
      logic [5:0]  cur_state;
      logic [5:0]  next_state;
      q_type       reward [4];
      logic [15:0] random_draw;
      logic [2:0]  random_action;
   } agent_item_type;

   // mirror of the agent state with its own arithmetic
   class agent_scoreboard;
      longint unsigned alpha, gamma, zeta, epsilon;
      longint          setpoint;
      longint          qtab [Q_ENTRIES];
      longint          level [NUM_DRIVES];
      int              state_held, action_held;
      agent_result_type pending [$];
      int              failures, results_seen, explores;

      function new();
         alpha = 6554; gamma = 58982; zeta = 65209; epsilon = 52429;
         setpoint = 327680;
         foreach (qtab[i]) qtab[i] = 0;
         foreach (level[i]) level[i] = 0;
         state_held = 0; action_held = 0;
         failures = 0; results_seen = 0; explores = 0;
      endfunction

      function longint clip(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint scale(longint unsigned c, longint x);
         longint p;
         p = longint'(c) * x;
         return clip(p >>> 16);
      endfunction

      function longint magnitude(longint x);
         return clip(x < 0 ? -x : x);
      endfunction

      function int entry(int d, int s, int a);
         return (d * NUM_STATES + s) * NUM_ACTIONS + a;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_LEARN_RATE:  alpha = v[15:0];
            CSR_DISCOUNT:    gamma = v[15:0];
            CSR_DRIVE_DECAY: zeta = v[15:0];
            CSR_EXPLOIT:     epsilon = v[16:0];
            CSR_SETPOINT:    setpoint = longint'($signed(v));
            default: ;
         endcase
      endfunction

      function void note_item(agent_item_type it);
         agent_result_type r;
         longint best_dist, drv_dist, base, err, best_err, qmax, r_d, rpe;
         int need, greedy, k, sp;
         r = '0;
         if (it.operation == OP_SELECT) begin
            best_dist = 0; need = 0; greedy = 0;
            state_held = it.cur_state % NUM_STATES;
            for (int d = 0; d < NUM_DRIVES; d++) begin
               drv_dist = magnitude(clip(setpoint - level[d]));
               if (drv_dist > best_dist) begin
                  best_err = 64'sd999 * 65536;
                  base = clip(setpoint - scale(zeta, level[d]));
                  best_dist = drv_dist; need = d;
                  for (int a = 0; a < NUM_ACTIONS; a++) begin
                     err = magnitude(clip(base -
                        scale(65536 - gamma, qtab[entry(d, state_held, a)])));
                     if (err < best_err) begin
                        best_err = err; greedy = a;
                     end
                  end
               end
            end
            if (it.random_draw < epsilon) action_held = greedy;
            else begin
               action_held = it.random_action % NUM_ACTIONS;
               r.explored = 1'b1;
               explores++;
            end
            r.chosen_action = 3'(action_held);
            r.neediest_drive = 2'(need);
         end else begin
            sp = it.next_state % NUM_STATES;
            for (int d = 0; d < NUM_DRIVES; d++) begin
               r_d = it.reward[d];
               k = entry(d, state_held, action_held % NUM_ACTIONS);
               level[d] = clip(scale(zeta, level[d]) + r_d);
               qmax = qtab[entry(d, sp, 0)];
               for (int a = 1; a < NUM_ACTIONS; a++)
                  if (qtab[entry(d, sp, a)] > qmax) qmax = qtab[entry(d, sp, a)];
               rpe = clip(r_d + scale(gamma, qmax));
               rpe = clip(rpe - qtab[k]);
               qtab[k] = clip(qtab[k] + scale(alpha, rpe));
            end
            r.chosen_action = 3'(action_held);
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [7:0] word);
         agent_result_type got, want;
         got = word[5:0];
         results_seen++;
         if (pending.size() == 0) begin
            $error("result word with nothing pending: %h", word);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (got.chosen_action !== want.chosen_action) begin
            $error("chosen_action expected %0d actual %0d",
                   want.chosen_action, got.chosen_action);
            failures++;
         end
         if (got.neediest_drive !== want.neediest_drive) begin
            $error("neediest_drive expected %0d actual %0d",
                   want.neediest_drive, got.neediest_drive);
            failures++;
         end
         if (got.explored !== want.explored) begin
            $error("explored expected %0d actual %0d", want.explored, got.explored);
            failures++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 req_tuser = 0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   agent_scoreboard board = new();
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   bit  random_rsp = 1;
   int  items_sent = 0;

   multi_drive_q_learning_agent dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired with %0d results pending", board.pending.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stalls, or a long hold when asked
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         gap = random_rsp ? $urandom_range(0, 15) : 0;
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata);
      end
   end

   // caller drops csr_we after the last write of a burst
   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_item(agent_item_type it, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.operation;
      req_tdata <= {1'b0, it.random_action, it.random_draw, it.reward[3], it.reward[2],
                    it.reward[1], it.reward[0], it.next_state, it.cur_state};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(it);
      items_sent++;
   endtask

   function automatic q_type pick_reward();
      case ($urandom_range(0, 7))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 0;
         3: return $urandom;
         default: return q_type'($signed($urandom_range(0, 20 * 65536))) - 10 * 65536;
      endcase
   endfunction

   function automatic agent_item_type random_item(logic op);
      agent_item_type it;
      it.operation = op;
      it.cur_state = 6'($urandom);
      it.next_state = 6'($urandom);
      foreach (it.reward[i]) it.reward[i] = pick_reward();
      it.random_draw = 16'($urandom);
      it.random_action = 3'($urandom);
      return it;
   endfunction

   task automatic run_random(int count, bit with_gaps);
      agent_item_type it;
      for (int i = 0; i < count; i++) begin
         // mostly select/update pairs, with odd runs of either
         it = random_item(($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : i[0]);
         send_item(it, (with_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : 0);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      agent_item_type it;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: extremes of every field, both operations
      for (int i = 0; i < 20; i++) begin
         it = random_item(i[0]);
         it.cur_state = (i % 4 < 2) ? 6'd0 : 6'd63;
         it.next_state = (i % 4 == 1) ? 6'd63 : 6'd0;
         it.random_draw = (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0000 : 16'd52428;
         it.random_action = 3'(i % 8);
         foreach (it.reward[k]) it.reward[k] = (i % 5 == 0) ? Q_MAX :
                                                (i % 5 == 1) ? Q_MIN : it.reward[k];
         send_item(it, 0);
      end
      req_tvalid <= 1'b0;
      drain();

      // fill up behind a stalled receiver
      hold_rsp = 1;
      run_random(40, 0);
      drain();

      begin
         automatic logic [31:0] settings [4][5] = '{
            '{32'd65535, 32'd0, 32'd65535, 32'd65536, 32'h7fffffff},
            '{32'd0, 32'd65535, 32'd0, 32'd0, 32'h80000000},
            '{32'd32768, 32'd32768, 32'd49152, 32'd1, 32'd0},
            '{32'd6554, 32'd58982, 32'd65209, 32'd52429, 32'd327680}};
         for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 5; r++) write_csr(r[2:0], settings[p][r]);
            write_csr(CSR_UNUSED_INDEX, $urandom);
            csr_we <= 1'b0;
            random_rsp = (p != 2);
            run_random(150, p != 1);
            drain();
         end
         for (int r = 0; r < 5; r++) write_csr(r[2:0], $urandom);
         csr_we <= 1'b0;
         run_random(100, 1);
         drain();
      end

      $display("covered %0d items, %0d results, %0d explored selects, five register settings",
               items_sent, board.results_seen, board.explores);
      if (board.failures == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
